// File: rtl/atte_pkg.sv
// atte_pkg: shared types and constants for the ansi text terminal engine
// no dependencies
`timescale 1ns / 1ps
package atte_pkg;

    typedef struct packed {
        logic       command;
        logic [7:0] in_byte;
        logic [4:0] read_row;
        logic [6:0] read_column;
    } atte_in_t;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_column;
        logic [11:0] cursor_index;
        logic [7:0]  cell_char;
        logic [3:0]  cell_fg;
        logic [3:0]  cell_bg;
        logic        cell_blink;
    } atte_out_t;

    typedef enum logic [1:0] {
        PH_TEXT = 2'd0,
        PH_ESC  = 2'd1,
        PH_CSI  = 2'd2
    } atte_phase_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_BOT_RD,
        ST_BOT_WR,
        ST_OUT
    } atte_state_t;

    localparam logic [1:0] CFG_COLS = 2'd0;
    localparam logic [1:0] CFG_ROWS = 2'd1;
    localparam logic [1:0] CFG_FG   = 2'd2;
    localparam logic [1:0] CFG_BG   = 2'd3;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

endpackage

// File: rtl/atte_cell_ram.sv
// atte_cell_ram: single port screen store, registered read
// depends on nothing
`timescale 1ns / 1ps
module atte_cell_ram #(
    parameter int AW = 12,
    parameter int DW = 17
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: rtl/ansi_text_terminal_engine.sv
// ansi_text_terminal_engine: top level, parser, cursor control and sequencer
// depends on atte_pkg and atte_cell_ram
`timescale 1ns / 1ps
//
// usage
// - s_ channel carries one item per handshake: a stream byte (command 0) or a
//   cell read (command 1); m_ channel returns one result item per input item
// - cfg channel writes screen size and default colours; the user must write them
//   only while the block is idle, as the block itself does not enforce it
// - a text byte is executed and written to the store, then its result is put in the
//   output register; a cell read addresses the store, reads it, then outputs
// - a scroll walks the store cell by cell, reading then writing back each cell,
//   as the store has a single port
// - only one item is in flight at a time
// - after reset a clearing pass writes every store entry, during which s_ready
//   is low; cfg writes are taken throughout
// - the result sits in an output register; a new item is taken only once the
//   previous result has been taken, so a stalled receiver stalls the input
//
module ansi_text_terminal_engine
    import atte_pkg::*;
#(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 32,
    parameter int MAX_ARGS    = 3
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  atte_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output atte_out_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int AIW   = $clog2(MAX_ARGS + 1);

    // configuration
    logic [7:0] cols_cfg_reg;
    logic [5:0] rows_cfg_reg;
    logic [3:0] dfg_reg, dbg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_cfg_reg <= 8'd80;
            rows_cfg_reg <= 6'd25;
            dfg_reg      <= 4'd15;
            dbg_reg      <= 4'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_COLS: cols_cfg_reg <= cfg_data;
                CFG_ROWS: rows_cfg_reg <= cfg_data[5:0];
                CFG_FG:   dfg_reg      <= cfg_data[3:0];
                CFG_BG:   dbg_reg      <= cfg_data[3:0];
                default: ;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    // clamped geometry
    logic [CW-1:0] cols;
    logic [RW-1:0] rows;
    always_comb begin
        if (cols_cfg_reg == 8'd0) cols = CW'(1);
        else if (32'(cols_cfg_reg) > MAX_COLUMNS) cols = CW'(MAX_COLUMNS);
        else cols = CW'(cols_cfg_reg);
        if (rows_cfg_reg == 6'd0) rows = RW'(1);
        else if (32'(rows_cfg_reg) > MAX_ROWS) rows = RW'(MAX_ROWS);
        else rows = RW'(rows_cfg_reg);
    end

    // terminal state
    atte_state_t state_reg, state_next;
    logic [7:0] row_reg, col_reg, srow_reg, scol_reg;
    logic [3:0] fg_reg, bg_reg;
    logic       blink_reg;
    atte_phase_t phase_reg;
    logic [7:0] args_reg [MAX_ARGS];
    logic [AIW-1:0] argc_reg;
    logic [7:0] acc_reg;
    logic       innum_reg;
    atte_in_t   item_reg;
    atte_out_t  out_reg;
    logic       mvalid_reg;
    logic [AW:0] ptr_reg;       // sweep pointer
    logic [AW:0] end_reg;       // sweep end
    logic        scr_after_reg; // set cursor to last row after scroll

    // clamped cursor
    logic [7:0] crow, ccol;
    always_comb begin
        crow = (row_reg >= 8'(rows)) ? 8'(rows - 1'b1) : row_reg;
        ccol = (col_reg >= 8'(cols)) ? 8'(cols - 1'b1) : col_reg;
    end

    // store port
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [16:0]   ram_wdata, ram_rdata;

    atte_cell_ram #(.AW(AW), .DW(17)) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // one multiplier for row * columns, registered
    logic [7:0]    mul_row;
    logic [AW+1:0] mul_reg;
    always_ff @(posedge aclk) begin
        mul_reg <= (AW+2)'(mul_row) * (AW+2)'(cols);
    end

    logic [AW:0] total;
    assign total = (AW+1)'(rows) * (AW+1)'(cols);

    assign s_ready = (state_reg == ST_IDLE) && !mvalid_reg;
    assign m_valid = mvalid_reg;
    assign m_data  = out_reg;

    logic is_digit, rd_ok;
    assign is_digit = (item_reg.in_byte >= CH_0) && (item_reg.in_byte <= CH_9);
    assign rd_ok = (8'(item_reg.read_row) < 8'(rows)) &&
                   (8'(item_reg.read_column) < 8'(cols));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (ptr_reg == (AW+1)'(CELLS - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (s_valid && s_ready) state_next = ST_EXEC;
            ST_EXEC:   state_next = ST_RDWAIT;
            ST_RDWAIT: begin
                if (!scr_after_reg) state_next = ST_OUT;
                else if (32'(cols) < 32'(total)) state_next = ST_SCR_RD;
                else state_next = ST_BOT_RD;
            end
            ST_SCR_RD: state_next = ST_SCR_WR;
            ST_SCR_WR: begin
                if (ptr_reg + (AW+1)'(cols) + 1'b1 >= end_reg) state_next = ST_BOT_RD;
                else state_next = ST_SCR_RD;
            end
            ST_BOT_RD: state_next = ST_BOT_WR;
            ST_BOT_WR: begin
                if (ptr_reg + 1'b1 >= end_reg) state_next = ST_OUT;
                else state_next = ST_BOT_RD;
            end
            ST_OUT:    if (!mvalid_reg) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // store port drive
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = ptr_reg[AW-1:0];
        // clear fill always uses the reset colours
        ram_wdata = {1'b0, 4'd0, 4'd15, CH_SPACE};
        mul_row   = crow;
        unique case (state_reg)
            ST_CLEAR: ram_we = 1'b1;
            ST_IDLE:  mul_row = s_data.command ? 8'(s_data.read_row) : crow;
            ST_EXEC: begin
                ram_addr  = AW'(mul_reg + (AW+2)'(item_reg.command ?
                             8'(item_reg.read_column) : ccol));
                ram_wdata = {blink_reg, bg_reg, fg_reg, item_reg.in_byte};
                ram_we    = !item_reg.command && phase_reg == PH_TEXT &&
                            item_reg.in_byte != CH_ESC && item_reg.in_byte != CH_NUL &&
                            item_reg.in_byte != CH_LF;
            end
            ST_SCR_RD: ram_addr = AW'(ptr_reg + (AW+1)'(cols));
            ST_SCR_WR: begin
                ram_we = 1'b1;
                ram_wdata = ram_rdata;
            end
            ST_BOT_WR: begin
                ram_we = 1'b1;
                ram_wdata = {ram_rdata[16:8], CH_SPACE};
            end
            default: ;
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        logic [7:0] a;
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            ptr_reg    <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            srow_reg   <= '0;
            scol_reg   <= '0;
            fg_reg     <= 4'd15;
            bg_reg     <= 4'd0;
            blink_reg  <= 1'b0;
            phase_reg  <= PH_TEXT;
            argc_reg   <= '0;
            acc_reg    <= '0;
            innum_reg  <= 1'b0;
            mvalid_reg <= 1'b0;
            scr_after_reg <= 1'b0;
            for (int i = 0; i < MAX_ARGS; i++) args_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (mvalid_reg && m_ready) mvalid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR: ptr_reg <= ptr_reg + 1'b1;
                ST_IDLE: begin
                    // clamp at item start, as the cursor is seen on entry
                    if (s_valid && s_ready) begin
                        item_reg <= s_data;
                        row_reg  <= crow;
                        col_reg  <= ccol;
                    end
                end
                ST_EXEC: begin
                    out_reg.cell_char  <= '0;
                    out_reg.cell_fg    <= '0;
                    out_reg.cell_bg    <= '0;
                    out_reg.cell_blink <= 1'b0;
                    if (!item_reg.command) begin
                        priority case (phase_reg)
                            PH_ESC: begin
                                phase_reg <= (item_reg.in_byte == CH_LBR) ? PH_CSI : PH_TEXT;
                                argc_reg  <= '0;
                                acc_reg   <= '0;
                                innum_reg <= 1'b0;
                            end
                            PH_CSI: begin
                                if (is_digit) begin
                                    acc_reg <= 8'(acc_reg * 8'd10 + (item_reg.in_byte - CH_0));
                                    innum_reg <= 1'b1;
                                end else if (innum_reg && 32'(argc_reg) >= MAX_ARGS) begin
                                    phase_reg <= PH_TEXT;
                                    argc_reg <= '0; acc_reg <= '0; innum_reg <= 1'b0;
                                end else begin
                                    logic [7:0] av [MAX_ARGS];
                                    logic [AIW-1:0] ac;
                                    logic [3:0] nf, nb;
                                    logic nbl;
                                    for (int i = 0; i < MAX_ARGS; i++) av[i] = args_reg[i];
                                    ac = argc_reg;
                                    if (innum_reg) begin
                                        av[argc_reg[AIW-1:0] < AIW'(MAX_ARGS) ?
                                           argc_reg : '0] = acc_reg;
                                        ac = argc_reg + 1'b1;
                                    end
                                    for (int i = 0; i < MAX_ARGS; i++) args_reg[i] <= av[i];
                                    // a final byte ends the sequence and drops the count
                                    argc_reg  <= (item_reg.in_byte == CH_SEMI) ? ac : '0;
                                    acc_reg   <= '0;
                                    innum_reg <= 1'b0;
                                    if (item_reg.in_byte != CH_SEMI) begin
                                        phase_reg <= PH_TEXT;
                                        nf = fg_reg; nb = bg_reg; nbl = blink_reg;
                                        if (item_reg.in_byte == CH_M) begin
                                            for (int i = 0; i < MAX_ARGS; i++) begin
                                                a = av[i];
                                                if (32'(ac) > i) begin
                                                    if (a >= 8'd30 && a <= 8'd37) nf = 4'(a - 8'd30);
                                                    else if (a >= 8'd40 && a <= 8'd47)
                                                        nb = 4'(a - 8'd40);
                                                    else if (a == 8'd5 || a == 8'd6) nbl = 1'b1;
                                                    else if (a == 8'd25) nbl = 1'b0;
                                                    else if (a == 8'd0) begin
                                                        nf = dfg_reg; nb = dbg_reg; nbl = 1'b0;
                                                    end
                                                end
                                            end
                                        end else if (item_reg.in_byte == CH_H ||
                                                     item_reg.in_byte == CH_F) begin
                                            if (ac == AIW'(2)) begin
                                                srow_reg <= row_reg;
                                                scol_reg <= col_reg;
                                                row_reg  <= av[0];
                                                col_reg  <= av[1];
                                            end else if (ac == AIW'(1) && av[0] == 8'd0) begin
                                                row_reg <= srow_reg;
                                                col_reg <= scol_reg;
                                            end
                                        end
                                        fg_reg <= nf; bg_reg <= nb; blink_reg <= nbl;
                                    end
                                end
                            end
                            default: begin
                                phase_reg <= (item_reg.in_byte == CH_ESC) ? PH_ESC : PH_TEXT;
                                if (item_reg.in_byte == CH_LF) begin
                                    col_reg <= '0;
                                    if (row_reg + 1'b1 < 8'(rows)) row_reg <= row_reg + 1'b1;
                                    else scr_after_reg <= 1'b1;
                                end else if (item_reg.in_byte != CH_ESC &&
                                             item_reg.in_byte != CH_NUL) begin
                                    if (col_reg + 1'b1 >= 8'(cols)) begin
                                        col_reg <= '0;
                                        if (row_reg + 1'b1 >= 8'(rows)) scr_after_reg <= 1'b1;
                                        else row_reg <= row_reg + 1'b1;
                                    end else col_reg <= col_reg + 1'b1;
                                end
                            end
                        endcase
                    end
                end
                ST_RDWAIT: begin
                    // latch cell read data; set up a pending scroll at the last row
                    if (item_reg.command && rd_ok) begin
                        out_reg.cell_char  <= ram_rdata[7:0];
                        out_reg.cell_fg    <= ram_rdata[11:8];
                        out_reg.cell_bg    <= ram_rdata[15:12];
                        out_reg.cell_blink <= ram_rdata[16];
                    end
                    if (scr_after_reg) begin
                        scr_after_reg <= 1'b0;
                        row_reg  <= 8'(rows - 1'b1);
                        ptr_reg  <= '0;
                        end_reg  <= total;
                    end
                end
                ST_SCR_WR: begin
                    if (ptr_reg + (AW+1)'(cols) + 1'b1 >= end_reg)
                        ptr_reg <= end_reg - (AW+1)'(cols);
                    else
                        ptr_reg <= ptr_reg + 1'b1;
                end
                ST_BOT_WR: ptr_reg <= ptr_reg + 1'b1;
                ST_OUT: begin
                    if (!mvalid_reg) begin
                        mvalid_reg <= 1'b1;
                        out_reg.cursor_row    <= 5'(crow);
                        out_reg.cursor_column <= 7'(ccol);
                        out_reg.cursor_index  <= 12'(mul_reg + (AW+2)'(ccol));
                        // keep the cursor inside the screen between items
                        row_reg <= crow;
                        col_reg <= ccol;
                    end
                end
                default: ;
            endcase
        end
    end

    // index multiplier sees the clamped cursor in every state but idle, so
    // mul_reg is valid in the output state

    always_ff @(posedge aclk) begin
        if (aresetn) begin
            assert (!(m_valid && s_ready)) else $error("input taken with result pending");
            assert (!(state_reg == ST_CLEAR && s_ready)) else $error("input during clear");
        end
    end

    property p_hold;
        @(posedge aclk) disable iff (!aresetn) (m_valid && !m_ready) |=> $stable(m_data);
    endproperty
    a_hold: assert property (p_hold) else $error("result changed while stalled");

    property p_one;
        @(posedge aclk) disable iff (!aresetn) (s_valid && s_ready) |=> !s_ready;
    endproperty
    a_one: assert property (p_one) else $error("two items in flight");

    property p_cols;
        @(posedge aclk) disable iff (!aresetn) (cols != '0) && (rows != '0);
    endproperty
    a_geom: assert property (p_cols) else $error("zero geometry");
endmodule

// File: tb/sv/atte_checker.sv
// atte_checker: watches the item, result and register channels of the text terminal,
// keeps its own copy of the screen and parser and compares each result item
// depends on atte_pkg
`timescale 1ns / 1ps
module atte_checker
    import atte_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  atte_in_t   s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  atte_out_t  m_data,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         pending
);

    localparam int NCOLS = 128;
    localparam int NROWS = 32;
    localparam int NARGS = 3;

    logic [16:0]  scr [NROWS*NCOLS];
    int           row_q, col_q, row_s, col_s;
    logic [3:0]   fg_q, bg_q;
    logic         blink_q;
    atte_phase_t  phase_q;
    int           args_q [NARGS];
    int           nargs_q, acc_q;
    logic         digits_q;
    int           reg_cols, reg_rows;
    logic [3:0]   reg_fg, reg_bg;
    atte_out_t    result_q [$];

    function automatic int cols_eff();
        if (reg_cols < 1) return 1;
        if (reg_cols > NCOLS) return NCOLS;
        return reg_cols;
    endfunction

    function automatic int rows_eff();
        if (reg_rows < 1) return 1;
        if (reg_rows > NROWS) return NROWS;
        return reg_rows;
    endfunction

    function automatic void clamp_pos();
        if (row_q >= rows_eff()) row_q = rows_eff() - 1;
        if (col_q >= cols_eff()) col_q = cols_eff() - 1;
    endfunction

    function automatic void shift_screen();
        int c, tot;
        c = cols_eff();
        tot = c * rows_eff();
        for (int i = 0; i + c < tot; i++) scr[i] = scr[i+c];
        for (int i = tot - c; i < tot; i++) scr[i][7:0] = CH_SPACE;
    endfunction

    function automatic void leave_seq();
        phase_q = PH_TEXT;
        nargs_q = 0;
        acc_q = 0;
        digits_q = 1'b0;
    endfunction

    function automatic void write_glyph(logic [7:0] ch);
        scr[row_q*cols_eff() + col_q] = {blink_q, bg_q, fg_q, ch};
        col_q++;
        if (col_q >= cols_eff()) begin
            col_q = 0;
            row_q++;
            if (row_q >= rows_eff()) begin
                shift_screen();
                row_q = rows_eff() - 1;
            end
        end
    endfunction

    function automatic void do_sgr();
        int a;
        for (int i = 0; i < nargs_q && i < NARGS; i++) begin
            a = args_q[i];
            if (a >= 30 && a <= 37) fg_q = 4'(a - 30);
            else if (a >= 40 && a <= 47) bg_q = 4'(a - 40);
            else if (a == 5 || a == 6) blink_q = 1'b1;
            else if (a == 25) blink_q = 1'b0;
            else if (a == 0) begin
                fg_q = reg_fg;
                bg_q = reg_bg;
                blink_q = 1'b0;
            end
        end
    endfunction

    function automatic void do_position();
        if (nargs_q == 2) begin
            row_s = row_q;
            col_s = col_q;
            row_q = args_q[0];
            col_q = args_q[1];
        end else if (nargs_q == 1 && args_q[0] == 0) begin
            row_q = row_s;
            col_q = col_s;
        end
        clamp_pos();
    endfunction

    function automatic void take_byte(logic [7:0] b);
        if (phase_q == PH_ESC) begin
            if (b == CH_LBR) begin
                leave_seq();
                phase_q = PH_CSI;
            end else leave_seq();
        end else if (phase_q == PH_CSI) begin
            if (b >= CH_0 && b <= CH_9) begin
                acc_q = (acc_q * 10 + int'(b - CH_0)) & 8'hFF;
                digits_q = 1'b1;
                return;
            end
            if (digits_q) begin
                if (nargs_q >= NARGS) begin
                    leave_seq();
                    return;
                end
                args_q[nargs_q] = acc_q;
                nargs_q++;
                acc_q = 0;
                digits_q = 1'b0;
            end
            if (b == CH_SEMI) return;
            if (b == CH_M) do_sgr();
            else if (b == CH_H || b == CH_F) do_position();
            leave_seq();
        end else begin
            if (b == CH_ESC) phase_q = PH_ESC;
            else if (b == CH_NUL) begin
            end else if (b == CH_LF) begin
                if (row_q + 1 < rows_eff()) row_q++;
                else shift_screen();
                col_q = 0;
            end else write_glyph(b);
        end
    endfunction

    function automatic atte_out_t terminal_step(atte_in_t it);
        atte_out_t   r;
        logic [16:0] cell_word;
        cell_word = '0;
        clamp_pos();
        if (!it.command) take_byte(it.in_byte);
        else if (int'(it.read_row) < rows_eff() && int'(it.read_column) < cols_eff())
            cell_word = scr[int'(it.read_row)*cols_eff() + int'(it.read_column)];
        clamp_pos();
        r.cursor_row    = 5'(row_q);
        r.cursor_column = 7'(col_q);
        r.cursor_index  = 12'(row_q * cols_eff() + col_q);
        r.cell_char     = cell_word[7:0];
        r.cell_fg       = cell_word[11:8];
        r.cell_bg       = cell_word[15:12];
        r.cell_blink    = cell_word[16];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            fail_count = 0;
            reg_cols = 80;
            reg_rows = 25;
            reg_fg = 4'd15;
            reg_bg = 4'd0;
            for (int i = 0; i < NROWS*NCOLS; i++) scr[i] = {1'b0, 4'd0, 4'd15, CH_SPACE};
            row_q = 0; col_q = 0; row_s = 0; col_s = 0;
            fg_q = 4'd15; bg_q = 4'd0; blink_q = 1'b0;
            for (int i = 0; i < NARGS; i++) args_q[i] = 0;
            leave_seq();
            result_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_COLS: reg_cols = int'(cfg_data);
                    CFG_ROWS: reg_rows = int'(cfg_data[5:0]);
                    CFG_FG:   reg_fg = cfg_data[3:0];
                    CFG_BG:   reg_bg = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) result_q.push_back(terminal_step(s_data));
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected result item", int'(m_data), 0);
                end else begin
                    atte_out_t w;
                    w = result_q.pop_front();
                    if (m_data.cursor_row !== w.cursor_row)
                        report_mismatch("cursor_row", m_data.cursor_row, w.cursor_row);
                    if (m_data.cursor_column !== w.cursor_column)
                        report_mismatch("cursor_column", m_data.cursor_column, w.cursor_column);
                    if (m_data.cursor_index !== w.cursor_index)
                        report_mismatch("cursor_index", m_data.cursor_index, w.cursor_index);
                    if (m_data.cell_char !== w.cell_char)
                        report_mismatch("cell_char", m_data.cell_char, w.cell_char);
                    if (m_data.cell_fg !== w.cell_fg)
                        report_mismatch("cell_fg", m_data.cell_fg, w.cell_fg);
                    if (m_data.cell_bg !== w.cell_bg)
                        report_mismatch("cell_bg", m_data.cell_bg, w.cell_bg);
                    if (m_data.cell_blink !== w.cell_blink)
                        report_mismatch("cell_blink", m_data.cell_blink, w.cell_blink);
                end
            end
        end
        pending = result_q.size();
    end

endmodule

// File: tb/sv/tb_top.sv
// tb_top: stimulus and verdict for the ansi text terminal engine
// depends on atte_pkg, atte_checker and the block itself
`timescale 1ns / 1ps
module tb_top;
    import atte_pkg::*;

    localparam int LIMIT = 3000000;

    logic       aclk;
    logic       aresetn;
    logic       s_valid, s_ready;
    atte_in_t   s_data;
    logic       m_valid, m_ready;
    atte_out_t  m_data;
    logic       cfg_valid, cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    int         fail_count, pending;
    int         cycles = 0;
    int         sent;        // input items accepted so far
    bit         quiet;       // no idling on either side
    bit         hold_req;    // receiver holds off for a long stretch
    int         cur_cols, cur_rows;

    ansi_text_terminal_engine i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    atte_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // 8 ns clock
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic int idle_gap();
        if (quiet) return 0;
        return $urandom_range(0, 15);
    endfunction

    // watchdog on the whole run
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("[ansi_text_terminal_engine] ERROR");
            $finish;
        end
    end

    // receiver: random gap before each item, plus the one long hold-off
    initial begin
        int g;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            g = idle_gap();
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_req = 1'b0;
            end else if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // one input item: optional gap with valid low, then hold until taken
    task automatic send_item(input atte_in_t it);
        int g;
        g = idle_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic feed(input logic [7:0] b);
        atte_in_t it;
        it = '0;
        it.command = 1'b0;
        it.in_byte = b;
        it.read_row = 5'($urandom);
        it.read_column = 7'($urandom);
        send_item(it);
    endtask

    task automatic read_cell(input int r, input int c);
        atte_in_t it;
        it.command = 1'b1;
        it.in_byte = 8'($urandom);
        it.read_row = 5'(r);
        it.read_column = 7'(c);
        send_item(it);
    endtask

    task automatic feed_number(input int n);
        string s;
        s = $sformatf("%0d", n);
        for (int i = 0; i < s.len(); i++) feed(s[i]);
    endtask

    // escape, bracket, n arguments separated by semicolons, then the final byte
    task automatic feed_csi(input int n, input int a0, input int a1, input int a2,
                            input int a3, input logic [7:0] fin);
        int a [4];
        a = '{a0, a1, a2, a3};
        feed(CH_ESC);
        feed(CH_LBR);
        for (int i = 0; i < n; i++) begin
            if (i > 0) feed(CH_SEMI);
            feed_number(a[i]);
        end
        feed(fin);
    endtask

    // sender waits until every result item is back
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        drain();
        repeat (20) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_COLS) cur_cols = (val == 0) ? 1 : (val > 128 ? 128 : int'(val));
        if (idx == CFG_ROWS)
            cur_rows = (val[5:0] == 0) ? 1 : (val[5:0] > 32 ? 32 : int'(val[5:0]));
    endtask

    function automatic int sgr_arg();
        case ($urandom_range(0, 6))
            0: return 0;
            1: return $urandom_range(30, 37);
            2: return $urandom_range(40, 47);
            3: return $urandom_range(5, 6);
            4: return 25;
            5: return $urandom_range(0, 255);
            default: return $urandom_range(256, 999);
        endcase
    endfunction

    // mostly well-formed text and sequences, some noise and broken sequences;
    // n counts input items
    task automatic random_items(input int n);
        int k, na, start;
        logic [7:0] fin;
        start = sent;
        while (sent - start < n) begin
            k = $urandom_range(0, 99);
            if (k < 5) feed(8'($urandom));
            else if (k < 40) feed(8'($urandom_range(32, 126)));
            else if (k < 48) feed(CH_LF);
            else if (k < 63) begin
                if ($urandom_range(0, 3) == 0)
                    read_cell($urandom_range(0, 31), $urandom_range(0, 127));
                else
                    read_cell($urandom_range(0, cur_rows - 1), $urandom_range(0, cur_cols - 1));
            end else if (k < 78) begin
                na = $urandom_range(0, 3);
                feed_csi(na, sgr_arg(), sgr_arg(), sgr_arg(), 0, CH_M);
            end else if (k < 86) begin
                fin = $urandom_range(0, 1) ? CH_H : CH_F;
                if ($urandom_range(0, 7) == 0)
                    feed_csi(2, $urandom_range(0, 255), $urandom_range(0, 255), 0, 0, fin);
                else
                    feed_csi(2, $urandom_range(0, cur_rows), $urandom_range(0, cur_cols),
                             0, 0, fin);
            end else if (k < 90) begin
                feed_csi($urandom_range(0, 1), 0, 0, 0, 0, CH_H);
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        feed(CH_ESC);
                        feed(8'($urandom));
                    end
                    1: feed_csi(4, sgr_arg(), sgr_arg(), sgr_arg(), sgr_arg(), CH_M);
                    2: feed_csi($urandom_range(0, 3), sgr_arg(), sgr_arg(), sgr_arg(), 0,
                                8'($urandom));
                    default: feed_csi(1, $urandom_range(1, 255), 0, 0, 0, CH_H);
                endcase
            end
        end
    endtask

    initial begin
        sent      = 0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        cur_cols  = 80;
        cur_rows  = 25;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_COLS;
        cfg_data  = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes of the byte and read fields, every sequence kind
        feed(8'h41);
        feed(8'hFF);
        feed(CH_NUL);
        feed(CH_LF);
        feed_csi(3, 31, 45, 5, 0, CH_M);
        feed(8'h78);
        feed_csi(2, 2, 3, 0, 0, CH_H);
        feed(8'h7E);
        feed_csi(1, 0, 0, 0, 0, CH_F);
        read_cell(0, 0);
        read_cell(31, 127);
        feed(CH_ESC);
        feed(8'h51);                        // escape not followed by bracket
        feed_csi(4, 1, 2, 3, 4, CH_M);      // one argument too many
        feed_csi(1, 9, 0, 0, 0, 8'h5A);     // unknown final byte
        read_cell(1, 1);

        // small screen, many scrolls
        write_reg(CFG_COLS, 8'd8);
        write_reg(CFG_ROWS, 8'd4);
        write_reg(CFG_FG, 8'($urandom_range(0, 15)));
        write_reg(CFG_BG, 8'($urandom_range(0, 15)));
        random_items(150);
        hold_req = 1'b1;                    // block fills up and stalls its input
        random_items(150);
        drain();                            // sender pause until all results are in
        random_items(150);

        // single cell screen
        write_reg(CFG_COLS, 8'd1);
        write_reg(CFG_ROWS, 8'd1);
        write_reg(CFG_FG, 8'd0);
        write_reg(CFG_BG, 8'd15);
        random_items(80);

        // largest screen via out-of-range register values, few items
        write_reg(CFG_COLS, 8'd255);
        write_reg(CFG_ROWS, 8'd63);
        write_reg(CFG_FG, 8'd15);
        write_reg(CFG_BG, 8'd0);
        feed_csi(2, 255, 255, 0, 0, CH_H);
        feed(8'h5A);
        random_items(30);

        // zero sizes clamp to one; cursor left far outside
        write_reg(CFG_COLS, 8'd0);
        write_reg(CFG_ROWS, 8'd0);
        random_items(40);

        // medium screen, with a stretch of back-to-back traffic
        write_reg(CFG_COLS, 8'd16);
        write_reg(CFG_ROWS, 8'd6);
        write_reg(CFG_FG, 8'($urandom_range(0, 15)));
        write_reg(CFG_BG, 8'($urandom_range(0, 15)));
        random_items(150);
        quiet = 1'b1;
        random_items(150);
        quiet = 1'b0;
        random_items(150);

        drain();
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[ansi_text_terminal_engine] OK");
        end else begin
            $display("[ansi_text_terminal_engine] ERROR");
        end
        $finish;
    end

endmodule
